@@ hdl/hed_pkg.sv @@
// Package for the character reference decoder: types, constants and window sizes.
package hed_pkg;

    // Bytes examined per window and the width of a count up to that size.
    localparam int WINDOW_BYTES = 12;
    localparam int CNT_W        = $clog2(WINDOW_BYTES + 1);
    localparam int POS_W        = $clog2(WINDOW_BYTES);
    // The input fields carry twelve bytes; wider windows read zero bytes above.
    localparam int FIELD_BYTES  = 12;
    localparam int PAD_BYTES    = 16;

    // Character codes used by the decoder.
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    // Printable range for decimal references and the radix.
    localparam logic [6:0] DEC_LO   = 7'd32;
    localparam logic [6:0] DEC_SAT  = 7'd127;
    localparam logic [3:0] DEC_RADIX = 4'd10;

    // One input window item.
    typedef struct packed {
        logic [63:0] window_head;
        logic [31:0] window_tail;
        logic [3:0]  valid_bytes;
    } t_win_item;

    // One decoded result item.
    typedef struct packed {
        logic [3:0] consumed;
        logic [7:0] decoded_char;
    } t_res_item;

endpackage

@@ hdl/hed_if.sv @@
// Valid/ready channel interfaces for the window input and the result output.
interface hed_win_if;
    logic        valid;
    logic        ready;
    logic [63:0] window_head;
    logic [31:0] window_tail;
    logic [3:0]  valid_bytes;

    modport source (output valid, output window_head, output window_tail,
                    output valid_bytes, input ready);
    modport sink   (input valid, input window_head, input window_tail,
                    input valid_bytes, output ready);
endinterface

interface hed_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] consumed;
    logic [7:0] decoded_char;

    modport source (output valid, output consumed, output decoded_char, input ready);
    modport sink   (input valid, input consumed, input decoded_char, output ready);
endinterface

@@ hdl/hed_decode.sv @@
// Combinational decode of one window into a reference length and a byte.
module hed_decode (
    input  hed_pkg::t_win_item i_item,
    output hed_pkg::t_res_item o_res
);

    localparam int WB = hed_pkg::WINDOW_BYTES;

    logic [8*hed_pkg::PAD_BYTES-1:0] pad;
    logic [7:0]                      w [WB];
    logic [hed_pkg::CNT_W-1:0]       vb;
    logic                            semi_found;
    logic [hed_pkg::POS_W-1:0]       semi_pos;
    logic                            is_lt, is_gt, is_amp, is_quot, is_nbsp, is_dec;
    logic                            run;
    logic                            hi_nz;
    logic [3:0]                      d0, d1, d2;
    logic [9:0]                      val;
    logic [7:0]                      dec_char;

    // Unpack the window; bytes beyond the input fields read as zero.
    assign pad = {{(8*(hed_pkg::PAD_BYTES - hed_pkg::FIELD_BYTES)){1'b0}},
                  i_item.window_tail, i_item.window_head};

    always_comb begin
        for (int k = 0; k < WB; k++) begin
            w[k] = pad[8*k +: 8];
        end
    end

    // Clamp the valid count to the window size.
    always_comb begin
        if (hed_pkg::CNT_W'(i_item.valid_bytes) > hed_pkg::CNT_W'(WB)) begin
            vb = hed_pkg::CNT_W'(WB);
        end else begin
            vb = hed_pkg::CNT_W'(i_item.valid_bytes);
        end
    end

    // Find the first semicolon among the valid bytes after the ampersand.
    always_comb begin
        semi_found = 1'b0;
        semi_pos   = '0;
        for (int k = WB - 1; k >= 1; k--) begin
            if ((hed_pkg::CNT_W'(k) < vb) && (w[k] == hed_pkg::CH_SEMI)) begin
                semi_found = 1'b1;
                semi_pos   = hed_pkg::POS_W'(k);
            end
        end
    end

    // Named references, each with its semicolon right after the name.
    assign is_lt   = (semi_pos == hed_pkg::POS_W'(3)) && (w[1] == hed_pkg::CH_L) &&
                     (w[2] == hed_pkg::CH_T);
    assign is_gt   = (semi_pos == hed_pkg::POS_W'(3)) && (w[1] == hed_pkg::CH_G) &&
                     (w[2] == hed_pkg::CH_T);
    assign is_amp  = (semi_pos == hed_pkg::POS_W'(4)) && (w[1] == hed_pkg::CH_A) &&
                     (w[2] == hed_pkg::CH_M) && (w[3] == hed_pkg::CH_P);
    assign is_quot = (semi_pos == hed_pkg::POS_W'(5)) && (w[1] == hed_pkg::CH_Q) &&
                     (w[2] == hed_pkg::CH_U) && (w[3] == hed_pkg::CH_O) &&
                     (w[4] == hed_pkg::CH_T);
    assign is_nbsp = (semi_pos == hed_pkg::POS_W'(5)) && (w[1] == hed_pkg::CH_N) &&
                     (w[2] == hed_pkg::CH_B) && (w[3] == hed_pkg::CH_S) &&
                     (w[4] == hed_pkg::CH_P);
    assign is_dec  = (vb > hed_pkg::CNT_W'(3)) && (w[1] == hed_pkg::CH_HASH);

    // Keep the last three leading digits and note whether any earlier digit was
    // nonzero; such a digit puts the value at a thousand or more, far above the
    // printable range. The low nibble of an ASCII digit is its value.
    always_comb begin
        run   = 1'b1;
        hi_nz = 1'b0;
        d0    = '0;
        d1    = '0;
        d2    = '0;
        for (int k = 2; k < WB; k++) begin
            run = run && (hed_pkg::POS_W'(k) < semi_pos) &&
                  (w[k] >= hed_pkg::CH_ZERO) && (w[k] <= hed_pkg::CH_NINE);
            if (run) begin
                hi_nz = hi_nz || (d2 != 4'd0);
                d2    = d1;
                d1    = d0;
                d0    = w[k][3:0];
            end
        end
        val = (10'(d2) * 10'(hed_pkg::DEC_RADIX) + 10'(d1)) * 10'(hed_pkg::DEC_RADIX) +
              10'(d0);
        if (!hi_nz && (val >= 10'(hed_pkg::DEC_LO)) && (val < 10'(hed_pkg::DEC_SAT))) begin
            dec_char = val[7:0];
        end else begin
            dec_char = hed_pkg::CH_QMARK;
        end
    end

    // Pick the result; anything not recognized reports zero length.
    always_comb begin
        o_res = '0;
        if ((vb != '0) && (w[0] == hed_pkg::CH_AMP) && semi_found) begin
            if (is_lt) begin
                o_res.decoded_char = hed_pkg::CH_LT;
            end else if (is_gt) begin
                o_res.decoded_char = hed_pkg::CH_GT;
            end else if (is_amp) begin
                o_res.decoded_char = hed_pkg::CH_AMP;
            end else if (is_quot) begin
                o_res.decoded_char = hed_pkg::CH_QUOTE;
            end else if (is_nbsp) begin
                o_res.decoded_char = hed_pkg::CH_SPACE;
            end else if (is_dec) begin
                o_res.decoded_char = dec_char;
            end
            if (is_lt || is_gt || is_amp || is_quot || is_nbsp || is_dec) begin
                o_res.consumed = 4'(semi_pos + 1'b1);
            end
        end
    end

endmodule

@@ hdl/html_entity_decoder.sv @@
// Top level of the character reference decoder: input and result registers.
//
// Usage: windows of text that start at an ampersand arrive on i_win, each item
// carrying twelve bytes and a count of how many are valid. Each window gives
// exactly one item on o_res: the reference length (0 when the window does not
// start a recognized reference) and the decoded byte.
//
// An accepted item sits in the input register, and the decode logic between the
// input register and the result register captures its result there when the result
// register advances. Throughput is one item per cycle while o_res.ready stays high,
// set by the single register-to-register decode path.
//
// Reset clears both stage valid flags; no item is in flight afterwards.
// When the receiver stalls, the result register holds its item and the input
// register can still take one more item, so i_win.ready falls only once both
// registers are full. Ready follows o_res.ready within the same cycle.
module html_entity_decoder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hed_win_if.sink      i_win,
    hed_res_if.source    o_res
);

    logic                r_in_valid;
    hed_pkg::t_win_item  r_in;
    logic                r_out_valid;
    hed_pkg::t_res_item  r_out;
    hed_pkg::t_res_item  n_out;
    logic                advance;

    // The result register moves when it is empty or being taken.
    assign advance     = !r_out_valid || o_res.ready;
    assign i_win.ready = !r_in_valid || advance;

    hed_decode u_decode (
        .i_item (r_in),
        .o_res  (n_out)
    );

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_win.ready) begin
                r_in_valid <= i_win.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_win.ready && i_win.valid) begin
            r_in.window_head <= i_win.window_head;
            r_in.window_tail <= i_win.window_tail;
            r_in.valid_bytes <= i_win.valid_bytes;
        end
        if (advance && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.consumed     = r_out.consumed;
    assign o_res.decoded_char = r_out.decoded_char;

endmodule

@@ tb/html_entity_decoder_checker.sv @@
// Checker for the character reference decoder: predicts each result item and compares it.
module html_entity_decoder_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_win_valid,
    input  logic        i_win_ready,
    input  logic [63:0] i_window_head,
    input  logic [31:0] i_window_tail,
    input  logic [3:0]  i_valid_bytes,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [3:0]  i_consumed,
    input  logic [7:0]  i_decoded_char,
    output int          o_fail_count,
    output int          o_pending
);

    // Decoded items still owed by the block, oldest first.
    hed_pkg::t_res_item expected_results[$];
    int                 fail_total = 0;

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, exp_val);
        fail_total++;
    endtask

    // True when the bytes up to and including the semicolon spell the name exactly.
    function automatic bit name_hit(input logic [hed_pkg::PAD_BYTES-1:0][7:0] w,
                                    input int unsigned semi, input string nm);
        int k;
        if (semi + 1 != nm.len()) begin
            return 1'b0;
        end
        for (k = 0; k < nm.len(); k++) begin
            if (w[k] != nm.getc(k)) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Works out the reference length and decoded byte for one window.
    function automatic hed_pkg::t_res_item decode_reference(input hed_pkg::t_win_item it);
        logic [hed_pkg::PAD_BYTES-1:0][7:0] w;
        int unsigned                        valid;
        int unsigned                        semi;
        int unsigned                        value;
        int unsigned                        k;
        bit                                 hit;
        hed_pkg::t_res_item                 r;
        w = '0;
        w[hed_pkg::FIELD_BYTES-1:0] = {it.window_tail, it.window_head};
        r = '0;
        valid = 32'(it.valid_bytes);
        if (valid > hed_pkg::WINDOW_BYTES) begin
            valid = hed_pkg::WINDOW_BYTES;
        end
        if (valid == 0 || w[0] != hed_pkg::CH_AMP) begin
            return r;
        end
        // The first semicolon inside the valid bytes closes the reference.
        semi = 1;
        while (semi < valid && semi < hed_pkg::WINDOW_BYTES && w[semi] != hed_pkg::CH_SEMI) begin
            semi++;
        end
        if (semi >= valid || semi >= hed_pkg::WINDOW_BYTES) begin
            return r;
        end
        hit = 1'b1;
        if (name_hit(w, semi, "&lt;")) begin
            r.decoded_char = hed_pkg::CH_LT;
        end else if (name_hit(w, semi, "&gt;")) begin
            r.decoded_char = hed_pkg::CH_GT;
        end else if (name_hit(w, semi, "&amp;")) begin
            r.decoded_char = hed_pkg::CH_AMP;
        end else if (name_hit(w, semi, "&quot;")) begin
            r.decoded_char = hed_pkg::CH_QUOTE;
        end else if (name_hit(w, semi, "&nbsp;")) begin
            r.decoded_char = hed_pkg::CH_SPACE;
        end else if (valid > 3 && w[1] == hed_pkg::CH_HASH) begin
            // Leading digits form the value; the first other byte stops the sum.
            value = 0;
            k = 2;
            while (k < semi && w[k] >= hed_pkg::CH_ZERO && w[k] <= hed_pkg::CH_NINE) begin
                value = value * hed_pkg::DEC_RADIX + 32'(w[k] - hed_pkg::CH_ZERO);
                k++;
            end
            r.decoded_char = (value >= hed_pkg::DEC_LO && value < hed_pkg::DEC_SAT) ?
                             value[7:0] : hed_pkg::CH_QMARK;
        end else begin
            hit = 1'b0;
        end
        if (hit) begin
            r.consumed = 4'(semi + 1);
        end
        return r;
    endfunction

    // Compare accepted result items, then record the prediction for a new window.
    always @(posedge i_clk) begin : watch_channels
        hed_pkg::t_res_item want;
        hed_pkg::t_win_item seen;
        if (i_rst_n) begin
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result item with none pending, consumed",
                                    int'(i_consumed), 0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_consumed != want.consumed) begin
                        report_mismatch("consumed", int'(i_consumed), int'(want.consumed));
                    end
                    if (i_decoded_char != want.decoded_char) begin
                        report_mismatch("decoded_char", int'(i_decoded_char),
                                        int'(want.decoded_char));
                    end
                end
            end
            if (i_win_valid && i_win_ready) begin
                seen.window_head = i_window_head;
                seen.window_tail = i_window_tail;
                seen.valid_bytes = i_valid_bytes;
                expected_results.push_back(decode_reference(seen));
            end
        end
        o_fail_count = fail_total;
        o_pending    = expected_results.size();
    end

endmodule

@@ tb/html_entity_decoder_tb.sv @@
// Testbench top for the character reference decoder: clock, reset, stimulus and verdict.
module html_entity_decoder_tb;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 3;
    localparam int RANDOM_ITEMS   = 1500;
    localparam int HOLD_CYCLES    = 48;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    hed_win_if win_ch();
    hed_res_if res_ch();

    int send_idle_pct = 21;
    int recv_idle_pct = 75;
    bit hold_request  = 1'b0;
    int fail_count;
    int pending;
    int quiet_cycles  = 0;

    html_entity_decoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_win   (win_ch),
        .o_res   (res_ch)
    );

    html_entity_decoder_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_win_valid    (win_ch.valid),
        .i_win_ready    (win_ch.ready),
        .i_window_head  (win_ch.window_head),
        .i_window_tail  (win_ch.window_tail),
        .i_valid_bytes  (win_ch.valid_bytes),
        .i_res_valid    (res_ch.valid),
        .i_res_ready    (res_ch.ready),
        .i_consumed     (res_ch.consumed),
        .i_decoded_char (res_ch.decoded_char),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Receiver: random stalls, or one long hold-off when requested.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_request = 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: ends the run when neither channel moves an item for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (win_ch.valid && win_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Packs twelve bytes, byte 0 lowest, and a valid count into one window item.
    function automatic hed_pkg::t_win_item pack_window(
        input logic [hed_pkg::FIELD_BYTES-1:0][7:0] b, input logic [3:0] vb);
        hed_pkg::t_win_item it;
        it.window_head = b[7:0];
        it.window_tail = b[11:8];
        it.valid_bytes = vb;
        return it;
    endfunction

    // Window holding the given text, zero bytes after it.
    function automatic hed_pkg::t_win_item text_window(input string s, input logic [3:0] vb);
        logic [hed_pkg::FIELD_BYTES-1:0][7:0] b;
        int                                   k;
        b = '0;
        for (k = 0; k < s.len() && k < hed_pkg::FIELD_BYTES; k++) begin
            b[k] = s.getc(k);
        end
        return pack_window(b, vb);
    endfunction

    // Mostly well-formed references with random content, plus broken ones and noise.
    function automatic hed_pkg::t_win_item random_window();
        logic [hed_pkg::FIELD_BYTES-1:0][7:0] b;
        logic [3:0]                           vb;
        string                                nm;
        int                                   kind;
        int                                   n;
        int                                   k;
        for (k = 0; k < hed_pkg::FIELD_BYTES; k++) begin
            b[k] = 8'($urandom_range(255));
        end
        kind = $urandom_range(99);
        if (kind < 85) begin
            b[0] = hed_pkg::CH_AMP;
        end
        if (kind < 35) begin
            case ($urandom_range(4))
                0: nm = "&lt;";
                1: nm = "&gt;";
                2: nm = "&amp;";
                3: nm = "&quot;";
                default: nm = "&nbsp;";
            endcase
            for (k = 0; k < nm.len(); k++) begin
                b[k] = nm.getc(k);
            end
            if ($urandom_range(99) < 15) begin
                b[$urandom_range(nm.len() - 1, 1)] = 8'($urandom_range(255));
            end
        end else if (kind < 70) begin
            b[1] = hed_pkg::CH_HASH;
            n = $urandom_range(9);
            for (k = 0; k < n; k++) begin
                b[2 + k] = 8'(hed_pkg::CH_ZERO + $urandom_range(9));
            end
            b[2 + n] = hed_pkg::CH_SEMI;
            if (n > 0 && $urandom_range(99) < 15) begin
                b[$urandom_range(1 + n, 2)] = 8'($urandom_range(255));
            end
        end else if (kind < 85) begin
            b[$urandom_range(hed_pkg::FIELD_BYTES - 1, 1)] = hed_pkg::CH_SEMI;
        end
        if ($urandom_range(3) != 0) begin
            vb = 4'(hed_pkg::WINDOW_BYTES);
        end else begin
            vb = 4'($urandom_range(15));
        end
        return pack_window(b, vb);
    endfunction

    // Offers one window item after random idle cycles and waits for its acceptance.
    task automatic send_window(input hed_pkg::t_win_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            win_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        win_ch.valid       <= 1'b1;
        win_ch.window_head <= it.window_head;
        win_ch.window_tail <= it.window_tail;
        win_ch.valid_bytes <= it.valid_bytes;
        do @(posedge i_clk); while (!win_ch.ready);
    endtask

    // Stops offering items until every predicted result item has arrived.
    task automatic wait_drained();
        @(negedge i_clk);
        win_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Stimulus: reset, directed windows, then three random phases of idling.
    initial begin : stimulus
        int phase;
        int n;
        win_ch.valid       = 1'b0;
        win_ch.window_head = '0;
        win_ch.window_tail = '0;
        win_ch.valid_bytes = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Every named reference and the decimal corner cases.
        send_window(text_window("&lt;", 4'd12));
        send_window(text_window("&gt;", 4'd12));
        send_window(text_window("&amp;", 4'd12));
        send_window(text_window("&quot;", 4'd12));
        send_window(text_window("&nbsp;", 4'd12));
        send_window(text_window("&LT;", 4'd12));
        send_window(text_window("&lt ;", 4'd12));
        send_window(text_window("&#65;", 4'd12));
        send_window(text_window("&#0;", 4'd12));
        send_window(text_window("&#127;", 4'd12));
        send_window(text_window("&#126;", 4'd12));
        send_window(text_window("&#32;", 4'd12));
        send_window(text_window("&#0065;", 4'd12));
        send_window(text_window("&#1065;", 4'd12));
        send_window(text_window("&#;", 4'd12));
        send_window(text_window("&#;", 4'd3));
        send_window(text_window("&#4x5;", 4'd12));
        send_window(text_window("&#999999999;", 4'd12));
        send_window(text_window("&abcdefghij;", 4'd12));
        send_window(text_window("&abcdefghijk", 4'd12));
        send_window(text_window("&;", 4'd12));
        // Semicolon just past the valid count, counts above the window, empty window.
        send_window(text_window("&lt;", 4'd3));
        send_window(text_window("&lt;", 4'd15));
        send_window(text_window("&lt;", 4'd0));
        send_window(text_window("x&lt;", 4'd12));
        send_window(pack_window('1, 4'hF));
        send_window(pack_window('0, 4'h0));

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 21;
                    recv_idle_pct = 75;
                end
                1: begin
                    send_idle_pct = 75;
                    recv_idle_pct = 21;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (n = 0; n < RANDOM_ITEMS / 3; n++) begin
                // Long receiver hold-off at full rate so both stages fill up.
                if (phase == 2 && n == 200) begin
                    hold_request = 1'b1;
                end
                send_window(random_window());
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/hed_pkg.sv
hdl/hed_if.sv
hdl/hed_decode.sv
hdl/html_entity_decoder.sv
tb/html_entity_decoder_checker.sv
tb/html_entity_decoder_tb.sv
